FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the dirty rectangle finder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TDR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define TDR_NEVER(lbl, clk, rstn, cond, msg) \
  `TDR_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

FILE: hw/rtl/tdr_pkg.sv
// Package with constants, codes and control types of the dirty rectangle finder.
`default_nettype none

package tdr_pkg;

  localparam int unsigned MAX_TILE_COLS_DEF = 16;
  localparam int unsigned COORD_BITS_DEF    = 12;
  localparam int unsigned CFG_INDEX_BITS    = 3;

  localparam int unsigned AREA_LEFT_RST   = 0;
  localparam int unsigned AREA_TOP_RST    = 0;
  localparam int unsigned AREA_WIDTH_RST  = 1024;
  localparam int unsigned AREA_HEIGHT_RST = 768;
  localparam int unsigned TILE_WIDTH_RST  = 100;
  localparam int unsigned TILE_HEIGHT_RST = 100;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_AREA_LEFT   = 3'd0,
    REG_AREA_TOP    = 3'd1,
    REG_AREA_WIDTH  = 3'd2,
    REG_AREA_HEIGHT = 3'd3,
    REG_TILE_WIDTH  = 3'd4,
    REG_TILE_HEIGHT = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    ST_RUN   = 1'b0,
    ST_DRAIN = 1'b1
  } tdr_state_e;

  typedef struct packed {
    logic step;
    logic emit;
    logic skip;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic band_end;
    logic any_pending;
    logic col_changed;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tdr_pix_if.sv
// Pixel pair channel interface.
`default_nettype none

interface tdr_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_before;
  logic [31:0] pixel_after;

  modport source (output valid, output pixel_before, output pixel_after, input ready);
  modport sink (input valid, input pixel_before, input pixel_after, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tdr_rect_if.sv
// Rectangle result channel interface.
`default_nettype none

interface tdr_rect_if #(
  parameter int unsigned COORD_BITS = tdr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] rect_left;
  logic [COORD_BITS-1:0] rect_top;
  logic [COORD_BITS:0]   rect_width;
  logic [COORD_BITS:0]   rect_height;
  logic                  last_in_band;
  logic                  last_in_area;

  modport source (output valid, output rect_left, output rect_top, output rect_width,
                  output rect_height, output last_in_band, output last_in_area,
                  input ready);
  modport sink (input valid, input rect_left, input rect_top, input rect_width,
                input rect_height, input last_in_band, input last_in_area,
                output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tdr_cfg_if.sv
// Configuration write channel interface.
`default_nettype none

interface tdr_cfg_if #(
  parameter int unsigned COORD_BITS = tdr_pkg::COORD_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [tdr_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [COORD_BITS:0]                 data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tiled_dirty_rect_finder_unit.sv
// Top level of the tiled dirty rectangle finder.
//
//   Channel   Direction  Payload
//   pix_i     in         pixel_before, pixel_after
//   rect_o    out        rect_left, rect_top, rect_width, rect_height, last_in_band,
//                        last_in_area
//   cfg_i     in         index, data
//
// One pixel pair is taken per cycle while the block scans a band of tiles.
// After the last pixel of a band the controller drains the column boxes, one tile
// column per cycle up to the last changed column, and pixels wait.
// A full result register stalls the drain until the rectangle is taken.
// Reset clears the changed flags and the scan position; no clearing pass is needed.
// A configuration write to a defined register index restarts the scan at the area's first pixel.
`default_nettype none

module tiled_dirty_rect_finder_unit #(
  parameter int unsigned MAX_TILE_COLS = tdr_pkg::MAX_TILE_COLS_DEF,
  parameter int unsigned COORD_BITS    = tdr_pkg::COORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tdr_pix_if.sink     pix_i,
  tdr_rect_if.source  rect_o,
  tdr_cfg_if.sink     cfg_i
);

  tdr_pkg::cmd_t    cmd;
  tdr_pkg::status_t status;
  logic             in_ready;

  assign pix_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  tdr_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  tdr_datapath #(
    .MAX_TILE_COLS (MAX_TILE_COLS),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .pixel_before_i (pix_i.pixel_before),
    .pixel_after_i  (pix_i.pixel_after),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (rect_o.ready),
    .out_valid_o    (rect_o.valid),
    .rect_left_o    (rect_o.rect_left),
    .rect_top_o     (rect_o.rect_top),
    .rect_width_o   (rect_o.rect_width),
    .rect_height_o  (rect_o.rect_height),
    .last_in_band_o (rect_o.last_in_band),
    .last_in_area_o (rect_o.last_in_area)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/tdr_controller.sv
// Controller state machine that sequences pixel transfers and band drains.
`default_nettype none

`include "assert_macros.svh"

module tdr_controller (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire tdr_pkg::status_t status_i,
  output logic                  in_ready_o,
  output tdr_pkg::cmd_t         cmd_o
);

  tdr_pkg::tdr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdr_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tdr_pkg::ST_RUN: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          if (status_i.band_end) begin
            state_d = tdr_pkg::ST_DRAIN;
          end
        end
      end
      tdr_pkg::ST_DRAIN: begin
        if (!status_i.any_pending) begin
          cmd_o.done = 1'b1;
          state_d    = tdr_pkg::ST_RUN;
        end else if (status_i.col_changed) begin
          cmd_o.emit = status_i.out_free;
        end else begin
          cmd_o.skip = 1'b1;
        end
      end
      default: begin
        state_d = tdr_pkg::ST_RUN;
      end
    endcase
  end

  `TDR_ASSERT(a_band_end_drains, clk_i, rst_ni,
    (cmd_o.step && status_i.band_end) |=> (state_q == tdr_pkg::ST_DRAIN),
    "band end did not start a drain")
  `TDR_ASSERT(a_emit_ok, clk_i, rst_ni,
    cmd_o.emit |-> (status_i.col_changed && status_i.out_free),
    "rectangle emitted from an unchanged column or into a full slot")
  `TDR_ASSERT(a_drain_exits, clk_i, rst_ni,
    (state_q == tdr_pkg::ST_DRAIN && !status_i.any_pending) |=> (state_q == tdr_pkg::ST_RUN),
    "drain did not finish once no column was pending")
  `TDR_NEVER(a_no_step_in_drain, clk_i, rst_ni,
    (state_q == tdr_pkg::ST_DRAIN) && cmd_o.step,
    "pixel transferred during a drain")

endmodule

`default_nettype wire

FILE: hw/rtl/tdr_datapath.sv
// Datapath with configuration, scan position, per-column boxes and result register.
`default_nettype none

module tdr_datapath #(
  parameter int unsigned MAX_TILE_COLS = tdr_pkg::MAX_TILE_COLS_DEF,
  parameter int unsigned COORD_BITS    = tdr_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  input  wire logic [tdr_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [COORD_BITS:0]                cfg_data_i,
  input  wire logic [31:0]                        pixel_before_i,
  input  wire logic [31:0]                        pixel_after_i,
  input  wire tdr_pkg::cmd_t                      cmd_i,
  output tdr_pkg::status_t                        status_o,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic [COORD_BITS-1:0]                   rect_left_o,
  output logic [COORD_BITS-1:0]                   rect_top_o,
  output logic [COORD_BITS:0]                     rect_width_o,
  output logic [COORD_BITS:0]                     rect_height_o,
  output logic                                    last_in_band_o,
  output logic                                    last_in_area_o
);

  localparam int unsigned CB       = COORD_BITS;
  localparam int unsigned DW       = COORD_BITS + 1;
  localparam int unsigned COL_BITS = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam logic [DW-1:0] DIM_LIMIT = DW'(1) << CB;
  localparam logic [COL_BITS-1:0] COL_LAST = COL_BITS'(MAX_TILE_COLS - 1);

  function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (v > DIM_LIMIT) begin
      r = DIM_LIMIT;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CB-1:0] area_left_q, area_top_q;
  logic [DW-1:0] aw_q, ah_q, tw_q, th_q;
  logic          restart;

  always_comb begin
    restart = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tdr_pkg::REG_AREA_LEFT, tdr_pkg::REG_AREA_TOP, tdr_pkg::REG_AREA_WIDTH,
        tdr_pkg::REG_AREA_HEIGHT, tdr_pkg::REG_TILE_WIDTH,
        tdr_pkg::REG_TILE_HEIGHT: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q <= CB'(tdr_pkg::AREA_LEFT_RST);
      area_top_q  <= CB'(tdr_pkg::AREA_TOP_RST);
      aw_q        <= eff_dim(DW'(tdr_pkg::AREA_WIDTH_RST));
      ah_q        <= eff_dim(DW'(tdr_pkg::AREA_HEIGHT_RST));
      tw_q        <= eff_dim(DW'(tdr_pkg::TILE_WIDTH_RST));
      th_q        <= eff_dim(DW'(tdr_pkg::TILE_HEIGHT_RST));
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tdr_pkg::REG_AREA_LEFT:   area_left_q <= cfg_data_i[CB-1:0];
        tdr_pkg::REG_AREA_TOP:    area_top_q  <= cfg_data_i[CB-1:0];
        tdr_pkg::REG_AREA_WIDTH:  aw_q        <= eff_dim(cfg_data_i);
        tdr_pkg::REG_AREA_HEIGHT: ah_q        <= eff_dim(cfg_data_i);
        tdr_pkg::REG_TILE_WIDTH:  tw_q        <= eff_dim(cfg_data_i);
        tdr_pkg::REG_TILE_HEIGHT: th_q        <= eff_dim(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  logic [CB-1:0]            off_x_q, off_x_d, off_y_q, off_y_d;
  logic [CB-1:0]            x_in_tile_q, x_in_tile_d, y_in_tile_q, y_in_tile_d;
  logic [COL_BITS-1:0]      col_q, col_d, drain_idx_q, drain_idx_d;
  logic [MAX_TILE_COLS-1:0] changed_q, changed_d, drain_bit;
  logic                     area_end_q, area_end_d;

  logic [CB-1:0] min_x_q [MAX_TILE_COLS];
  logic [CB-1:0] max_x_q [MAX_TILE_COLS];
  logic [CB-1:0] min_y_q [MAX_TILE_COLS];
  logic [CB-1:0] max_y_q [MAX_TILE_COLS];

  logic [COL_BITS-1:0] rd_idx;
  logic [CB-1:0]       rd_min_x, rd_max_x, rd_min_y, rd_max_y;
  logic [CB-1:0]       wr_min_x, wr_max_x, wr_min_y, wr_max_y;
  logic                box_we, diff, row_end, area_end, band_end, x_tile_end;
  logic                out_free;

  assign rd_idx   = cmd_i.step ? col_q : drain_idx_q;
  assign rd_min_x = min_x_q[rd_idx];
  assign rd_max_x = max_x_q[rd_idx];
  assign rd_min_y = min_y_q[rd_idx];
  assign rd_max_y = max_y_q[rd_idx];

  assign diff       = pixel_before_i != pixel_after_i;
  assign row_end    = ({1'b0, off_x_q} + DW'(1)) >= aw_q;
  assign area_end   = row_end && (({1'b0, off_y_q} + DW'(1)) >= ah_q);
  assign band_end   = row_end && (area_end || (({1'b0, y_in_tile_q} + DW'(1)) >= th_q));
  assign x_tile_end = ({1'b0, x_in_tile_q} + DW'(1)) >= tw_q;
  assign drain_bit  = MAX_TILE_COLS'(1) << drain_idx_q;
  assign out_free   = !out_valid_o || out_ready_i;

  always_comb begin
    off_x_d     = off_x_q;
    off_y_d     = off_y_q;
    x_in_tile_d = x_in_tile_q;
    y_in_tile_d = y_in_tile_q;
    col_d       = col_q;
    drain_idx_d = drain_idx_q;
    changed_d   = changed_q;
    area_end_d  = area_end_q;
    box_we      = 1'b0;
    wr_min_x    = rd_min_x;
    wr_max_x    = rd_max_x;
    wr_min_y    = rd_min_y;
    wr_max_y    = rd_max_y;
    if (restart) begin
      off_x_d     = '0;
      off_y_d     = '0;
      x_in_tile_d = '0;
      y_in_tile_d = '0;
      col_d       = '0;
      drain_idx_d = '0;
      changed_d   = '0;
    end else if (cmd_i.step) begin
      if (diff) begin
        box_we = 1'b1;
        changed_d[col_q] = 1'b1;
        if (!changed_q[col_q]) begin
          wr_min_x = off_x_q;
          wr_max_x = off_x_q;
          wr_min_y = off_y_q;
          wr_max_y = off_y_q;
        end else begin
          if (off_x_q < rd_min_x) wr_min_x = off_x_q;
          if (off_x_q > rd_max_x) wr_max_x = off_x_q;
          if (off_y_q < rd_min_y) wr_min_y = off_y_q;
          if (off_y_q > rd_max_y) wr_max_y = off_y_q;
        end
      end
      if (band_end) begin
        area_end_d = area_end;
      end
      if (row_end) begin
        off_x_d     = '0;
        col_d       = '0;
        x_in_tile_d = '0;
        if (area_end) begin
          off_y_d     = '0;
          y_in_tile_d = '0;
        end else begin
          off_y_d     = off_y_q + CB'(1);
          y_in_tile_d = band_end ? '0 : y_in_tile_q + CB'(1);
        end
      end else begin
        off_x_d = off_x_q + CB'(1);
        if (x_tile_end) begin
          if (col_q != COL_LAST) begin
            col_d       = col_q + COL_BITS'(1);
            x_in_tile_d = '0;
          end
        end else begin
          x_in_tile_d = x_in_tile_q + CB'(1);
        end
      end
    end else if (cmd_i.emit) begin
      changed_d[drain_idx_q] = 1'b0;
      drain_idx_d = drain_idx_q + COL_BITS'(1);
    end else if (cmd_i.skip) begin
      drain_idx_d = drain_idx_q + COL_BITS'(1);
    end else if (cmd_i.done) begin
      drain_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q     <= '0;
      off_y_q     <= '0;
      x_in_tile_q <= '0;
      y_in_tile_q <= '0;
      col_q       <= '0;
      drain_idx_q <= '0;
      changed_q   <= '0;
      area_end_q  <= 1'b0;
    end else begin
      off_x_q     <= off_x_d;
      off_y_q     <= off_y_d;
      x_in_tile_q <= x_in_tile_d;
      y_in_tile_q <= y_in_tile_d;
      col_q       <= col_d;
      drain_idx_q <= drain_idx_d;
      changed_q   <= changed_d;
      area_end_q  <= area_end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      min_x_q[col_q] <= wr_min_x;
      max_x_q[col_q] <= wr_max_x;
      min_y_q[col_q] <= wr_min_y;
      max_y_q[col_q] <= wr_max_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rect_left_o    <= area_left_q + rd_min_x;
      rect_top_o     <= area_top_q + rd_min_y;
      rect_width_o   <= {1'b0, rd_max_x} - {1'b0, rd_min_x} + DW'(1);
      rect_height_o  <= {1'b0, rd_max_y} - {1'b0, rd_min_y} + DW'(1);
      last_in_band_o <= (changed_q & ~drain_bit) == '0;
      last_in_area_o <= area_end_q;
    end
  end

  always_comb begin
    status_o.band_end    = band_end;
    status_o.any_pending = |changed_q;
    status_o.col_changed = changed_q[drain_idx_q];
    status_o.out_free    = out_free;
  end

endmodule

`default_nettype wire

FILE: verif/tiled_dirty_rect_finder_unit_tb.sv
// Self-checking testbench for the tiled dirty rectangle finder, with its own tile tracker.
`default_nettype none

module tiled_dirty_rect_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLS          = tdr_pkg::MAX_TILE_COLS_DEF;
  localparam int unsigned CB            = tdr_pkg::COORD_BITS_DEF;
  localparam int unsigned DIM_MAX       = 1 << CB;
  localparam int unsigned MAX_GAP       = 19;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned RANDOM_ITEMS  = 130;

  localparam logic [tdr_pkg::CFG_INDEX_BITS-1:0] CFG_INDEX_UNUSED_LO = 3'd6;
  localparam logic [tdr_pkg::CFG_INDEX_BITS-1:0] CFG_INDEX_UNUSED_HI = 3'd7;

  typedef struct {
    logic [CB-1:0] left;
    logic [CB-1:0] top;
    logic [CB:0]   width;
    logic [CB:0]   height;
    logic          last_band;
    logic          last_area;
  } rect_t;

  logic clk;
  logic rst_n;

  tdr_pix_if  pix_if();
  tdr_rect_if rect_if();
  tdr_cfg_if  cfg_if();

  tiled_dirty_rect_finder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_if),
    .rect_o (rect_if),
    .cfg_i  (cfg_if)
  );

  int unsigned error_count = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int unsigned rect_hold_cycles = 0;
  rect_t       pending_rects[$];

  logic [CB-1:0] cfg_left, cfg_top;
  logic [CB:0]   cfg_area_w, cfg_area_h, cfg_tile_w, cfg_tile_h;

  bit            col_dirty[COLS];
  logic [CB-1:0] box_x0[COLS];
  logic [CB-1:0] box_x1[COLS];
  logic [CB-1:0] box_y0[COLS];
  logic [CB-1:0] box_y1[COLS];
  logic [CB-1:0] pos_x, pos_y, tile_x, tile_y;
  int unsigned   tile_col;

  function automatic int unsigned eff_size(logic [CB:0] v);
    if (v == 0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return 32'(v);
  endfunction

  function automatic void clear_scan();
    for (int i = 0; i < COLS; i++) begin
      col_dirty[i] = 1'b0;
      box_x0[i] = '0;
      box_x1[i] = '0;
      box_y0[i] = '0;
      box_y1[i] = '0;
    end
    pos_x = '0;
    pos_y = '0;
    tile_x = '0;
    tile_y = '0;
    tile_col = 0;
  endfunction

  function automatic void apply_reg_write(logic [tdr_pkg::CFG_INDEX_BITS-1:0] idx,
                                          logic [CB:0] data);
    case (idx)
      tdr_pkg::REG_AREA_LEFT: begin
        cfg_left = data[CB-1:0];
      end
      tdr_pkg::REG_AREA_TOP: begin
        cfg_top = data[CB-1:0];
      end
      tdr_pkg::REG_AREA_WIDTH: begin
        cfg_area_w = data;
      end
      tdr_pkg::REG_AREA_HEIGHT: begin
        cfg_area_h = data;
      end
      tdr_pkg::REG_TILE_WIDTH: begin
        cfg_tile_w = data;
      end
      tdr_pkg::REG_TILE_HEIGHT: begin
        cfg_tile_h = data;
      end
      default: begin
        return;
      end
    endcase
    clear_scan();
  endfunction

  // Updates the tile boxes for one pixel pair and queues the rectangles of a finished band.
  function automatic void track_pixel(logic [31:0] old_pix, logic [31:0] new_pix);
    int unsigned aw, ah, tw, th, c, dirty_total, emitted;
    bit row_end, area_end, band_end;
    rect_t r;
    aw = eff_size(cfg_area_w);
    ah = eff_size(cfg_area_h);
    tw = eff_size(cfg_tile_w);
    th = eff_size(cfg_tile_h);
    c = (tile_col >= COLS) ? COLS - 1 : tile_col;
    if (pos_x >= aw) pos_x = CB'(aw - 1);
    if (pos_y >= ah) pos_y = CB'(ah - 1);

    if (old_pix != new_pix) begin
      if (!col_dirty[c]) begin
        col_dirty[c] = 1'b1;
        box_x0[c] = pos_x;
        box_x1[c] = pos_x;
        box_y0[c] = pos_y;
        box_y1[c] = pos_y;
      end else begin
        if (pos_x < box_x0[c]) box_x0[c] = pos_x;
        if (pos_x > box_x1[c]) box_x1[c] = pos_x;
        if (pos_y < box_y0[c]) box_y0[c] = pos_y;
        if (pos_y > box_y1[c]) box_y1[c] = pos_y;
      end
    end

    row_end = (pos_x + 1 >= aw);
    area_end = row_end && (pos_y + 1 >= ah);
    band_end = row_end && (area_end || tile_y + 1 >= th);

    if (band_end) begin
      dirty_total = 0;
      for (int i = 0; i < COLS; i++) begin
        if (col_dirty[i]) dirty_total++;
      end
      emitted = 0;
      for (int i = 0; i < COLS; i++) begin
        if (col_dirty[i]) begin
          emitted++;
          r.left = cfg_left + box_x0[i];
          r.top = cfg_top + box_y0[i];
          r.width = {1'b0, box_x1[i]} - {1'b0, box_x0[i]} + (CB+1)'(1);
          r.height = {1'b0, box_y1[i]} - {1'b0, box_y0[i]} + (CB+1)'(1);
          r.last_band = (emitted == dirty_total);
          r.last_area = area_end;
          pending_rects.push_back(r);
          col_dirty[i] = 1'b0;
        end
      end
    end

    if (row_end) begin
      pos_x = '0;
      tile_col = 0;
      tile_x = '0;
      if (area_end) begin
        pos_y = '0;
        tile_y = '0;
      end else begin
        pos_y++;
        tile_y = band_end ? '0 : tile_y + CB'(1);
      end
    end else begin
      pos_x++;
      if (tile_x + 1 >= tw) begin
        if (c + 1 < COLS) begin
          tile_col = c + 1;
          tile_x = '0;
        end
      end else begin
        tile_x++;
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : rect_check
    rect_t want;
    if (rst_n && rect_if.valid && rect_if.ready) begin
      if (pending_rects.size() == 0) begin
        $error("unexpected rectangle: left %0d top %0d width %0d height %0d",
               rect_if.rect_left, rect_if.rect_top, rect_if.rect_width, rect_if.rect_height);
        error_count++;
      end else begin
        want = pending_rects.pop_front();
        check_field("rect_left", 32'(want.left), 32'(rect_if.rect_left));
        check_field("rect_top", 32'(want.top), 32'(rect_if.rect_top));
        check_field("rect_width", 32'(want.width), 32'(rect_if.rect_width));
        check_field("rect_height", 32'(want.height), 32'(rect_if.rect_height));
        check_field("last_in_band", 32'(want.last_band), 32'(rect_if.last_in_band));
        check_field("last_in_area", 32'(want.last_area), 32'(rect_if.last_in_area));
      end
    end
  end

  initial begin : rect_sink
    int unsigned pause;
    rect_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rect_hold_cycles > 0) begin
        rect_if.ready <= 1'b0;
        repeat (rect_hold_cycles) @(posedge clk);
        rect_hold_cycles = 0;
      end
      pause = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (pause > 0) begin
        rect_if.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rect_if.ready <= 1'b1;
      do @(posedge clk);
      while (!(rect_if.valid && rect_if.ready) && rect_hold_cycles == 0);
    end
  end

  task automatic send_pixel(logic [31:0] old_pix, logic [31:0] new_pix);
    int unsigned pause;
    pause = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (pause > 0) begin
      pix_if.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_before <= old_pix;
    pix_if.pixel_after <= new_pix;
    do @(posedge clk);
    while (!pix_if.ready);
    track_pixel(old_pix, new_pix);
  endtask

  task automatic send_random_pixels(int unsigned count, int unsigned diff_pct);
    logic [31:0] old_pix, new_pix;
    for (int unsigned i = 0; i < count; i++) begin
      old_pix = $urandom;
      new_pix = old_pix;
      if ($urandom_range(0, 99) < diff_pct) begin
        if ($urandom_range(0, 1) == 0) begin
          new_pix = old_pix ^ (32'h1 << $urandom_range(0, 31));
        end else begin
          new_pix = ~old_pix ^ $urandom;
          if (new_pix == old_pix) new_pix = ~old_pix;
        end
      end
      send_pixel(old_pix, new_pix);
    end
  endtask

  // Stops the pixel stream and lets every outstanding rectangle arrive.
  task automatic wait_drained();
    int unsigned waited;
    pix_if.valid <= 1'b0;
    waited = 0;
    while (pending_rects.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_rects.size() > 0) begin
      $error("%0d expected rectangles never arrived", pending_rects.size());
      error_count++;
      pending_rects.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tdr_pkg::CFG_INDEX_BITS-1:0] idx, logic [CB:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg_write(idx, data);
    @(posedge clk);
  endtask

  task automatic load_geometry(logic [CB:0] left, logic [CB:0] top, logic [CB:0] aw,
                               logic [CB:0] ah, logic [CB:0] tw, logic [CB:0] th);
    wait_drained();
    write_reg(tdr_pkg::REG_AREA_LEFT, left);
    write_reg(tdr_pkg::REG_AREA_TOP, top);
    write_reg(tdr_pkg::REG_AREA_WIDTH, aw);
    write_reg(tdr_pkg::REG_AREA_HEIGHT, ah);
    write_reg(tdr_pkg::REG_TILE_WIDTH, tw);
    write_reg(tdr_pkg::REG_TILE_HEIGHT, th);
  endtask

  task automatic test_restart_on_write();
    send_random_pixels(8, 100);
    load_geometry(0, 0, 6, 2, 2, 2);
    send_random_pixels(12, 50);
  endtask

  // Right tile column is one pixel wide and the bottom band one row tall.
  task automatic test_edge_tiles();
    logic [31:0] old_pix;
    bit differs;
    load_geometry(0, 0, 5, 4, 2, 3);
    for (int i = 0; i < 20; i++) begin
      old_pix = i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
      differs = (i % 4 == 0) || (i == 13);
      send_pixel(old_pix, differs ? ~old_pix : old_pix);
    end
  endtask

  task automatic test_zero_sizes();
    load_geometry(4090, 4094, 3, 0, 0, 0);
    send_random_pixels(3, 100);
    send_random_pixels(3, 40);
  endtask

  // Writes to unused indexes fall in the middle of a band and must leave the scan alone.
  task automatic test_unused_index();
    load_geometry(10, 20, 4, 2, 2, 1);
    send_random_pixels(3, 100);
    wait_drained();
    write_reg(CFG_INDEX_UNUSED_LO, 13'h1FFF);
    write_reg(CFG_INDEX_UNUSED_HI, 13'h0000);
    send_random_pixels(13, 70);
  endtask

  task automatic test_result_backpressure();
    load_geometry(0, 0, 16, 2, 1, 1);
    tx_gaps_on = 1'b0;
    rect_hold_cycles = 300;
    send_random_pixels(32, 100);
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_geometry();
    int unsigned sent, aw_reg, ah_reg, tw_reg, th_reg, pixels;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      aw_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
      ah_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      case ($urandom_range(0, 5))
        0: tw_reg = 0;
        1: tw_reg = $urandom_range(DIM_MAX + 1, 2 * DIM_MAX - 1);
        default: tw_reg = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 5))
        0: th_reg = 0;
        1: th_reg = $urandom_range(DIM_MAX + 1, 2 * DIM_MAX - 1);
        default: th_reg = $urandom_range(1, 4);
      endcase
      load_geometry((CB+1)'($urandom_range(0, DIM_MAX - 1)),
                    (CB+1)'($urandom_range(0, DIM_MAX - 1)),
                    (CB+1)'(aw_reg), (CB+1)'(ah_reg), (CB+1)'(tw_reg), (CB+1)'(th_reg));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      pixels = eff_size((CB+1)'(aw_reg)) * eff_size((CB+1)'(ah_reg));
      pixels += $urandom_range(0, pixels);
      send_random_pixels(pixels, $urandom_range(10, 60));
      sent += pixels;
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Origins at the top of the coordinate range wrap, and zero or oversize tiles are clamped.
  task automatic test_extreme_sizes();
    logic [31:0] old_pix;
    bit differs;
    load_geometry((CB+1)'(DIM_MAX - 2), (CB+1)'(DIM_MAX - 1), 6, 3, 0,
                  (CB+1)'(2 * DIM_MAX - 1));
    for (int i = 0; i < 18; i++) begin
      old_pix = $urandom;
      differs = (i == 0) || (i == 11) || (i == 17) || ($urandom_range(0, 3) == 0);
      send_pixel(old_pix, differs ? ~old_pix : old_pix);
    end
    load_geometry(0, (CB+1)'(DIM_MAX - 1), 1, 4, (CB+1)'(DIM_MAX), (CB+1)'(DIM_MAX));
    for (int i = 0; i < 8; i++) begin
      old_pix = $urandom;
      differs = (i == 0) || (i == 3) || ($urandom_range(0, 2) == 0);
      send_pixel(old_pix, differs ? ~old_pix : old_pix);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tiled_dirty_rect_finder_unit verification failed");
    $finish;
  end

  initial begin
    cfg_left = CB'(tdr_pkg::AREA_LEFT_RST);
    cfg_top = CB'(tdr_pkg::AREA_TOP_RST);
    cfg_area_w = (CB+1)'(tdr_pkg::AREA_WIDTH_RST);
    cfg_area_h = (CB+1)'(tdr_pkg::AREA_HEIGHT_RST);
    cfg_tile_w = (CB+1)'(tdr_pkg::TILE_WIDTH_RST);
    cfg_tile_h = (CB+1)'(tdr_pkg::TILE_HEIGHT_RST);
    clear_scan();
    rst_n <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.pixel_before <= '0;
    pix_if.pixel_after <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= tdr_pkg::REG_AREA_LEFT;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_restart_on_write();
    test_edge_tiles();
    test_zero_sizes();
    test_unused_index();
    test_result_backpressure();
    test_random_geometry();
    test_extreme_sizes();
    wait_drained();

    if (error_count == 0) begin
      $display("tiled_dirty_rect_finder_unit verification clean");
    end else begin
      $display("tiled_dirty_rect_finder_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tdr_pkg.sv
hw/rtl/tdr_pix_if.sv
hw/rtl/tdr_rect_if.sv
hw/rtl/tdr_cfg_if.sv
hw/rtl/tdr_controller.sv
hw/rtl/tdr_datapath.sv
hw/rtl/tiled_dirty_rect_finder_unit.sv
verif/tiled_dirty_rect_finder_unit_tb.sv
